// File: rtl/core/ckpc_pkg.sv
// ----------------------------------------------------------------------------
// ckpc_pkg
// Types, register map and colour helpers for the chroma-key compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package ckpc_pkg;

  // APB address width: six registers at word spacing
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  // Alpha is eight fractional bits, one quotient bit per divider cell
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned N_CELLS = ALPHA_W;

  // Register indices (word address bits)
  typedef enum logic [2:0] {
    REG_SOURCE_FORMAT = 3'd0,
    REG_KEY_RED       = 3'd1,
    REG_KEY_GREEN     = 3'd2,
    REG_KEY_BLUE      = 3'd3,
    REG_KEY_TOLERANCE = 3'd4,
    REG_FEATHER_WIDTH = 3'd5
  } reg_idx_t;

  // Source formats
  localparam logic FMT_RGB888 = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic       source_format;
    logic [7:0] key_red;
    logic [7:0] key_green;
    logic [7:0] key_blue;
    logic [7:0] key_tolerance;
    logic [7:0] feather_width;
  } cfg_t;

  // Pixel request travelling down the pipeline
  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        dst;
    logic [15:0]        opaque;
    logic               keyed;
    logic               blend;
    logic [7:0]         rem;
    logic [ALPHA_W-1:0] alpha;
  } item_t;

  // 5-bit channel to 8 bits by bit replication
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // 6-bit channel to 8 bits by bit replication
  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // fg*alpha + bg*(256-alpha), rounded, divided by 256
  function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
                                     input logic [ALPHA_W-1:0] alpha);
    logic [8:0]  inv;
    logic [16:0] acc;
    inv = 9'd256 - {1'b0, alpha};
    acc = ({9'd0, fg} * {9'd0, alpha}) + ({9'd0, bg} * {8'd0, inv}) + 17'd128;
    return acc[15:8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ckpc_if.sv
// ----------------------------------------------------------------------------
// ckpc_if
// Valid/ready channels for source/destination pixels and write results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ckpc_pix_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  src_red;
  logic [7:0]  src_green;
  logic [7:0]  src_blue;
  logic [15:0] src_packed;
  logic [15:0] dst_pixel;

  modport source (output valid, src_red, src_green, src_blue, src_packed, dst_pixel,
                  input ready);
  modport sink   (input valid, src_red, src_green, src_blue, src_packed, dst_pixel,
                  output ready);
endinterface

interface ckpc_pix_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [15:0] out_pixel;

  modport source (output valid, write_enable, out_pixel, input ready);
  modport sink   (input valid, write_enable, out_pixel, output ready);
endinterface

`default_nettype wire

// File: rtl/core/chroma_key_pixel_compositor.sv
// ----------------------------------------------------------------------------
// chroma_key_pixel_compositor
// Chroma-key compositor with soft-edge alpha blend onto an RGB565 target.
// ----------------------------------------------------------------------------
// One pixel request is taken every clock and one write result leaves every
// clock, so sustained rate is one pixel per cycle under free-flowing output.
// Each pixel passes a decode/distance register, a row of eight divider
// cells that each resolve one bit of the blend alpha and pass the request on,
// and the blend/output register. Every stage holds its request independently,
// so bubbles close up under back-pressure and new pixels keep entering while
// a finished result waits. Registers are written over APB at word addresses
// 0x00..0x14 and should only be changed while the pipeline is empty.
`default_nettype none

module chroma_key_pixel_compositor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  ckpc_pix_in_if.sink                      pix_in,
  ckpc_pix_out_if.source                   pix_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ckpc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ckpc_pkg::DATA_W-1:0] pwdata,
  output      logic [ckpc_pkg::DATA_W-1:0] prdata,
  output      logic                        pready
);

  ckpc_pkg::cfg_t     cfg;
  ckpc_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  logic                        front_valid;
  logic                        front_ready;
  ckpc_pkg::item_t             front_item;
  logic [ckpc_pkg::N_CELLS-1:0] cell_valid;
  logic [ckpc_pkg::N_CELLS-1:0] cell_ready;
  ckpc_pkg::item_t             cell_item [ckpc_pkg::N_CELLS];

  // register file
  assign pready  = 1'b1;
  assign reg_idx = ckpc_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        ckpc_pkg::REG_SOURCE_FORMAT: cfg.source_format <= pwdata[0];
        ckpc_pkg::REG_KEY_RED:       cfg.key_red       <= pwdata[7:0];
        ckpc_pkg::REG_KEY_GREEN:     cfg.key_green     <= pwdata[7:0];
        ckpc_pkg::REG_KEY_BLUE:      cfg.key_blue      <= pwdata[7:0];
        ckpc_pkg::REG_KEY_TOLERANCE: cfg.key_tolerance <= pwdata[7:0];
        ckpc_pkg::REG_FEATHER_WIDTH: cfg.feather_width <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (reg_idx)
      ckpc_pkg::REG_SOURCE_FORMAT: prdata = {31'd0, cfg.source_format};
      ckpc_pkg::REG_KEY_RED:       prdata = {24'd0, cfg.key_red};
      ckpc_pkg::REG_KEY_GREEN:     prdata = {24'd0, cfg.key_green};
      ckpc_pkg::REG_KEY_BLUE:      prdata = {24'd0, cfg.key_blue};
      ckpc_pkg::REG_KEY_TOLERANCE: prdata = {24'd0, cfg.key_tolerance};
      ckpc_pkg::REG_FEATHER_WIDTH: prdata = {24'd0, cfg.feather_width};
      default:                     prdata = '0;
    endcase
  end

  // decode and distance
  ckpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .src_red    (pix_in.src_red),
    .src_green  (pix_in.src_green),
    .src_blue   (pix_in.src_blue),
    .src_packed (pix_in.src_packed),
    .dst_pixel  (pix_in.dst_pixel),
    .out_valid  (front_valid),
    .out_ready  (front_ready),
    .out_item   (front_item)
  );

  // divider row, one alpha bit per cell
  for (genvar i = 0; i < ckpc_pkg::N_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      ckpc_div_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .feather_width (cfg.feather_width),
        .in_valid      (front_valid),
        .in_ready      (front_ready),
        .in_item       (front_item),
        .out_valid     (cell_valid[i]),
        .out_ready     (cell_ready[i]),
        .out_item      (cell_item[i])
      );
    end else begin : g_next
      ckpc_div_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .feather_width (cfg.feather_width),
        .in_valid      (cell_valid[i-1]),
        .in_ready      (cell_ready[i-1]),
        .in_item       (cell_item[i-1]),
        .out_valid     (cell_valid[i]),
        .out_ready     (cell_ready[i]),
        .out_item      (cell_item[i])
      );
    end
  end

  // blend and output register
  ckpc_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cell_valid[ckpc_pkg::N_CELLS-1]),
    .in_ready     (cell_ready[ckpc_pkg::N_CELLS-1]),
    .in_item      (cell_item[ckpc_pkg::N_CELLS-1]),
    .out_valid    (pix_out.valid),
    .out_ready    (pix_out.ready),
    .write_enable (pix_out.write_enable),
    .out_pixel    (pix_out.out_pixel)
  );

  // input only stalls when every stage is full and the result is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (front_valid && (&cell_valid) && pix_out.valid && !pix_out.ready))
    else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire

// File: rtl/core/ckpc_front.sv
// ----------------------------------------------------------------------------
// ckpc_front
// Source decode, key distance and band classification, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ckpc_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ckpc_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [7:0]          src_red,
  input  wire logic [7:0]          src_green,
  input  wire logic [7:0]          src_blue,
  input  wire logic [15:0]         src_packed,
  input  wire logic [15:0]         dst_pixel,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      ckpc_pkg::item_t     out_item
);

  logic [7:0]      r, g, b;
  logic [15:0]     opaque;
  logic [7:0]      d_r, d_g, d_b, d_rg, key_dist;
  logic [8:0]      band_top;
  logic            keyed, band;
  ckpc_pkg::item_t item_next;

  // select and widen the source
  always_comb begin
    if (cfg.source_format == ckpc_pkg::FMT_RGB565) begin
      r      = ckpc_pkg::widen5(src_packed[15:11]);
      g      = ckpc_pkg::widen6(src_packed[10:5]);
      b      = ckpc_pkg::widen5(src_packed[4:0]);
      opaque = src_packed;
    end else begin
      r      = src_red;
      g      = src_green;
      b      = src_blue;
      opaque = ckpc_pkg::pack565(src_red, src_green, src_blue);
    end
  end

  // Chebyshev distance to the key colour
  always_comb begin
    d_r      = ckpc_pkg::absdiff(r, cfg.key_red);
    d_g      = ckpc_pkg::absdiff(g, cfg.key_green);
    d_b      = ckpc_pkg::absdiff(b, cfg.key_blue);
    d_rg     = (d_g > d_r) ? d_g : d_r;
    key_dist = (d_b > d_rg) ? d_b : d_rg;
    band_top = {1'b0, cfg.key_tolerance} + {1'b0, cfg.feather_width};
    keyed    = (key_dist <= cfg.key_tolerance);
    band     = (cfg.feather_width != 8'd0) && ({1'b0, key_dist} < band_top);
  end

  always_comb begin
    item_next.red    = r;
    item_next.green  = g;
    item_next.blue   = b;
    item_next.dst    = dst_pixel;
    item_next.opaque = opaque;
    item_next.keyed  = keyed;
    item_next.blend  = !keyed && band;
    // below the feather width whenever blend is set
    item_next.rem    = key_dist - cfg.key_tolerance;
    item_next.alpha  = '0;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

  // a request is never both keyed out and blended
  a_keyed_not_blend: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.keyed && out_item.blend))
    else $error("keyed request also marked for blending");

endmodule

`default_nettype wire

// File: rtl/core/ckpc_div_cell.sv
// ----------------------------------------------------------------------------
// ckpc_div_cell
// One restoring-division step of the alpha quotient, with its stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module ckpc_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      feather_width,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire ckpc_pkg::item_t in_item,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      ckpc_pkg::item_t out_item
);

  logic [8:0]      rem2;
  logic [8:0]      diff;
  logic            take;
  ckpc_pkg::item_t item_next;

  // shift remainder, trial subtract, shift quotient bit in
  always_comb begin
    rem2            = {in_item.rem, 1'b0};
    diff            = rem2 - {1'b0, feather_width};
    take            = (rem2 >= {1'b0, feather_width});
    item_next       = in_item;
    item_next.rem   = take ? diff[7:0] : rem2[7:0];
    item_next.alpha = {in_item.alpha[ckpc_pkg::ALPHA_W-2:0], take};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

  // partial remainder stays below the divisor in the band
  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.blend) |-> (out_item.rem < feather_width))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

// File: rtl/core/ckpc_blend.sv
// ----------------------------------------------------------------------------
// ckpc_blend
// Final selection: keyed out, alpha blend over the destination, or opaque.
// ----------------------------------------------------------------------------
`default_nettype none

module ckpc_blend (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire ckpc_pkg::item_t in_item,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      logic            write_enable,
  output      logic [15:0]     out_pixel
);

  logic [7:0]  bg_r, bg_g, bg_b;
  logic [7:0]  nr, ng, nb;
  logic        we_next;
  logic [15:0] pix_next;

  // blend each channel against the widened destination
  always_comb begin
    bg_r = ckpc_pkg::widen5(in_item.dst[15:11]);
    bg_g = ckpc_pkg::widen6(in_item.dst[10:5]);
    bg_b = ckpc_pkg::widen5(in_item.dst[4:0]);
    nr   = ckpc_pkg::mix(in_item.red,   bg_r, in_item.alpha);
    ng   = ckpc_pkg::mix(in_item.green, bg_g, in_item.alpha);
    nb   = ckpc_pkg::mix(in_item.blue,  bg_b, in_item.alpha);
  end

  always_comb begin
    if (in_item.keyed) begin
      we_next  = 1'b0;
      pix_next = 16'd0;
    end else if (in_item.blend) begin
      we_next  = 1'b1;
      pix_next = ckpc_pkg::pack565(nr, ng, nb);
    end else begin
      we_next  = 1'b1;
      pix_next = in_item.opaque;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      write_enable <= we_next;
      out_pixel    <= pix_next;
    end
  end

  // keyed-out results carry a zero pixel
  a_keyed_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (out_pixel == 16'd0))
    else $error("keyed result with non-zero pixel");

endmodule

`default_nettype wire
